// File: rtl/core/hpl_pkg.sv
`timescale 1ns / 1ps
package hpl_pkg;

   localparam int MULT_W          = 31;
   localparam int PERIOD_W        = 16;
   localparam int PERIOD_BITS_DEF = 16;
   localparam int PROD_W          = 2 * MULT_W;
   localparam int PC_W            = 4;
   localparam logic [MULT_W-1:0] MULT_MAX = {MULT_W{1'b1}};

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_GCD_INIT,
      OP_DIV_GCD,
      OP_GCD_SHIFT,
      OP_DIV_Q,
      OP_MUL,
      OP_SAT,
      OP_SETR,
      OP_EMIT
   } op_type;

   typedef enum logic [3:0] {
      C_NEXT,
      C_ALWAYS,
      C_NO_ACCEPT,
      C_R_ZERO,
      C_OVF,
      C_B_ZERO,
      C_DIV_BUSY,
      C_NOT_LAST,
      C_OUT_FULL
   } cond_type;

   typedef struct packed {
      cond_type          cond;
      logic [PC_W-1:0]   target;
      op_type            op;
   } uword_type;

   typedef struct packed {
      op_type op;
   } ctrl_type;

   typedef struct packed {
      logic accept;
      logic r_zero;
      logic ovf;
      logic b_zero;
      logic div_busy;
      logic last;
      logic out_full;
   } stat_type;

   localparam logic [PC_W-1:0] L_IDLE = 4'd0;
   localparam logic [PC_W-1:0] L_GCDT = 4'd4;
   localparam logic [PC_W-1:0] L_DIVW = 4'd6;
   localparam logic [PC_W-1:0] L_QDIV = 4'd8;
   localparam logic [PC_W-1:0] L_QW   = 4'd9;
   localparam logic [PC_W-1:0] L_SETR = 4'd12;
   localparam logic [PC_W-1:0] L_FIN  = 4'd13;
   localparam logic [PC_W-1:0] L_EMIT = 4'd14;

   // control store
   function automatic uword_type ucode(input logic [PC_W-1:0] pc);
      uword_type w;
      w = '{cond: C_ALWAYS, target: L_IDLE, op: OP_NOP};
      case (pc)
         4'd0:  w = '{cond: C_NO_ACCEPT, target: L_IDLE, op: OP_LOAD};
         4'd1:  w = '{cond: C_R_ZERO,    target: L_SETR, op: OP_NOP};
         4'd2:  w = '{cond: C_OVF,       target: L_FIN,  op: OP_NOP};
         4'd3:  w = '{cond: C_NEXT,      target: L_IDLE, op: OP_GCD_INIT};
         4'd4:  w = '{cond: C_B_ZERO,    target: L_QDIV, op: OP_NOP};
         4'd5:  w = '{cond: C_NEXT,      target: L_IDLE, op: OP_DIV_GCD};
         4'd6:  w = '{cond: C_DIV_BUSY,  target: L_DIVW, op: OP_NOP};
         4'd7:  w = '{cond: C_ALWAYS,    target: L_GCDT, op: OP_GCD_SHIFT};
         4'd8:  w = '{cond: C_NEXT,      target: L_IDLE, op: OP_DIV_Q};
         4'd9:  w = '{cond: C_DIV_BUSY,  target: L_QW,   op: OP_NOP};
         4'd10: w = '{cond: C_NEXT,      target: L_IDLE, op: OP_MUL};
         4'd11: w = '{cond: C_ALWAYS,    target: L_FIN,  op: OP_SAT};
         4'd12: w = '{cond: C_NEXT,      target: L_IDLE, op: OP_SETR};
         4'd13: w = '{cond: C_NOT_LAST,  target: L_IDLE, op: OP_NOP};
         4'd14: w = '{cond: C_OUT_FULL,  target: L_EMIT, op: OP_EMIT};
         4'd15: w = '{cond: C_ALWAYS,    target: L_IDLE, op: OP_NOP};
         default: w = '{cond: C_ALWAYS,  target: L_IDLE, op: OP_NOP};
      endcase
      return w;
   endfunction

endpackage

// File: rtl/core/hpl_div.sv
`timescale 1ns / 1ps
module hpl_div
   import hpl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [MULT_W-1:0] dividend,
   input  logic [MULT_W-1:0] divisor,
   output logic [MULT_W-1:0] quo,
   output logic [MULT_W-1:0] rem,
   output logic              busy
);

   localparam int CNT_W = $clog2(MULT_W + 1);

   logic [MULT_W-1:0] quo_ff, quo_in;
   logic [MULT_W-1:0] rem_ff, rem_in;
   logic [MULT_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [MULT_W:0]   trial;
   logic [MULT_W:0]   diff;

   // one quotient bit per cycle, restoring
   always_comb begin
      trial  = {rem_ff, quo_ff[MULT_W-1]};
      diff   = trial - {1'b0, dsr_ff};
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = CNT_W'(MULT_W);
      end else if (cnt_ff != '0) begin
         if (!diff[MULT_W]) begin
            rem_in = diff[MULT_W-1:0];
            quo_in = {quo_ff[MULT_W-2:0], 1'b1};
         end else begin
            rem_in = trial[MULT_W-1:0];
            quo_in = {quo_ff[MULT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quo  = quo_ff;
   assign rem  = rem_ff;
   assign busy = (cnt_ff != '0);

endmodule

// File: rtl/core/hpl_dp.sv
`timescale 1ns / 1ps
module hpl_dp
   import hpl_pkg::*;
#(
   parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_type            ctrl,
   output stat_type            stat,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [PERIOD_W-1:0] req_tdata,
   input  logic                req_tlast,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata,
   output logic                rsp_tuser
);

   localparam logic [MULT_W-1:0] PMASK = MULT_W'((64'd1 << PERIOD_BITS) - 64'd1);

   logic [MULT_W-1:0] p_ff, p_in;
   logic              last_ff, last_in;
   logic [MULT_W-1:0] r_ff, r_in;
   logic              ovf_ff, ovf_in;
   logic [MULT_W-1:0] a_ff, a_in;
   logic [MULT_W-1:0] b_ff, b_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              vld_ff, vld_in;
   logic [MULT_W-1:0] hyp_ff, hyp_in;
   logic              oflag_ff, oflag_in;

   logic              accept;
   logic              out_full;
   logic [MULT_W-1:0] p_raw;
   logic              div_start;
   logic [MULT_W-1:0] div_dvd;
   logic [MULT_W-1:0] div_dsr;
   logic [MULT_W-1:0] div_quo;
   logic [MULT_W-1:0] div_rem;
   logic              div_busy;

   assign req_tready = (ctrl.op == OP_LOAD) && !reset;
   assign accept     = req_tvalid && req_tready;
   assign out_full   = vld_ff && !rsp_tready;
   assign p_raw      = MULT_W'(req_tdata) & PMASK;

   assign div_start = (ctrl.op == OP_DIV_GCD) || (ctrl.op == OP_DIV_Q);
   assign div_dvd   = (ctrl.op == OP_DIV_Q) ? r_ff : a_ff;
   assign div_dsr   = (ctrl.op == OP_DIV_Q) ? a_ff : b_ff;

   hpl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .quo      (div_quo),
      .rem      (div_rem),
      .busy     (div_busy)
   );

   always_comb begin
      p_in     = p_ff;
      last_in  = last_ff;
      r_in     = r_ff;
      ovf_in   = ovf_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      prod_in  = prod_ff;
      hyp_in   = hyp_ff;
      oflag_in = oflag_ff;
      vld_in   = vld_ff && !rsp_tready;
      case (ctrl.op)
         OP_LOAD: begin
            if (accept) begin
               p_in    = (p_raw == '0) ? MULT_W'(1) : p_raw;
               last_in = req_tlast;
            end
         end
         OP_GCD_INIT: begin
            a_in = r_ff;
            b_in = p_ff;
         end
         OP_GCD_SHIFT: begin
            a_in = b_ff;
            b_in = div_rem;
         end
         OP_MUL: begin
            prod_in = PROD_W'(div_quo) * PROD_W'(p_ff);
         end
         OP_SAT: begin
            if (prod_ff > PROD_W'(MULT_MAX)) begin
               r_in   = MULT_MAX;
               ovf_in = 1'b1;
            end else begin
               r_in = prod_ff[MULT_W-1:0];
            end
         end
         OP_SETR: begin
            r_in = p_ff;
         end
         OP_EMIT: begin
            if (!out_full) begin
               hyp_in   = r_ff;
               oflag_in = ovf_ff;
               vld_in   = 1'b1;
               r_in     = '0;
               ovf_in   = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_ff   <= '0;
         ovf_ff <= 1'b0;
         vld_ff <= 1'b0;
      end else begin
         r_ff   <= r_in;
         ovf_ff <= ovf_in;
         vld_ff <= vld_in;
      end
      p_ff     <= p_in;
      last_ff  <= last_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      prod_ff  <= prod_in;
      hyp_ff   <= hyp_in;
      oflag_ff <= oflag_in;
   end

   assign stat.accept   = accept;
   assign stat.r_zero   = (r_ff == '0);
   assign stat.ovf      = ovf_ff;
   assign stat.b_zero   = (b_ff == '0);
   assign stat.div_busy = div_busy;
   assign stat.last     = last_ff;
   assign stat.out_full = out_full;

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = {1'b0, hyp_ff};
   assign rsp_tuser  = oflag_ff;

endmodule

// File: rtl/core/hpl_seq.sv
`timescale 1ns / 1ps
module hpl_seq
   import hpl_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  stat_type stat,
   output ctrl_type ctrl
);

   logic [PC_W-1:0] pc_ff, pc_in;
   uword_type       word;
   logic            take;

   assign word = ucode(pc_ff);

   always_comb begin
      case (word.cond)
         C_NEXT:      take = 1'b0;
         C_ALWAYS:    take = 1'b1;
         C_NO_ACCEPT: take = !stat.accept;
         C_R_ZERO:    take = stat.r_zero;
         C_OVF:       take = stat.ovf;
         C_B_ZERO:    take = stat.b_zero;
         C_DIV_BUSY:  take = stat.div_busy;
         C_NOT_LAST:  take = !stat.last;
         C_OUT_FULL:  take = stat.out_full;
         default:     take = 1'b1;
      endcase
      pc_in = take ? word.target : pc_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= L_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign ctrl.op = word.op;

endmodule

// File: rtl/core/hyperperiod_lcm.sv
`timescale 1ns / 1ps
// channel   dir  tdata                          tuser       tlast
// req_      in   [15:0] period                  -           is_last
// rsp_      out  [30:0] hyperperiod, [31] zero  [0] overflow  -
//
// a microcoded sequencer steps a small datapath; one item is taken per pass.
// first item of a set: load, then set the multiple to the period; saturated: load only.
// further items: Euclid gcd of multiple and period, each step one shift-subtract divide,
// then the multiple over the gcd, times the period, saturated; the last item then emits.
// synchronous reset clears the running multiple, flag, sequencer and output.
// a held result stalls the emit step, and with it the next item.
module hyperperiod_lcm
   import hpl_pkg::*;
#(
   parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [PERIOD_W-1:0] req_tdata,   // [15:0] period
   input  logic                req_tlast,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata,   // [30:0] hyperperiod, [31] zero
   output logic                rsp_tuser    // [0] overflow
);

   ctrl_type ctrl;
   stat_type stat;

   hpl_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   hpl_dp #(
      .PERIOD_BITS (PERIOD_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .stat       (stat),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   a_idle_div: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !stat.div_busy)
      else $error("divider busy while taking an item");

   a_ovf_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[MULT_W-1:0] == MULT_MAX))
      else $error("overflow flagged without saturation");

   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[MULT_W-1:0] != '0))
      else $error("zero hyperperiod emitted");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_EMIT && !stat.out_full) |=> (stat.r_zero && !stat.ovf))
      else $error("set state not cleared after emit");

endmodule

// File: tb/hyperperiod_lcm_test.sv
`timescale 1ns / 1ps
module hyperperiod_lcm_test;
   import hpl_pkg::*;

   localparam int CYCLE_LIMIT  = 10000000;
   localparam int RANDOM_ITEMS = 1800;
   localparam int HOLD_CYCLES  = 3000;
   localparam int DRAIN_CYCLES = 1200;

   typedef struct packed {
      logic [PERIOD_W-1:0] period;
      logic                last;
   } period_item_type;

   typedef struct packed {
      logic [MULT_W-1:0] hyper;
      logic              ovf;
   } hyper_result_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [PERIOD_W-1:0] req_tdata = '0;   // [15:0] period
   logic                req_tlast = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [31:0]         rsp_tdata;         // [30:0] hyperperiod, [31] zero
   logic                rsp_tuser;         // [0] overflow

   period_item_type  pending_periods[$];
   hyper_result_type hyper_expected[$];

   logic [MULT_W-1:0] run_multiple = '0;
   logic              overflow_seen = 1'b0;

   int  cycle_count = 0;
   int  results_seen = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   int  mismatches = 0;
   int  items_queued = 0;
   wire calm = (cycle_count >= 20000) && (cycle_count < 50000);

   hyperperiod_lcm uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // fold one period into the running multiple, queue the hyperperiod on the last
   function automatic void fold_period(input logic [PERIOD_W-1:0] raw, input logic last);
      longint unsigned  p, a, b, rem, prod;
      hyper_result_type res;
      p = raw & ((64'd1 << PERIOD_BITS_DEF) - 1);
      if (p == 0) p = 1;
      if (run_multiple == '0) begin
         run_multiple = p[MULT_W-1:0];
      end else if (!overflow_seen) begin
         a = run_multiple;
         b = p;
         while (b != 0) begin
            rem = a % b;
            a = b;
            b = rem;
         end
         prod = (run_multiple / a) * p;
         if (prod > MULT_MAX) begin
            run_multiple = MULT_MAX;
            overflow_seen = 1'b1;
         end else begin
            run_multiple = prod[MULT_W-1:0];
         end
      end
      if (last) begin
         res.hyper = run_multiple;
         res.ovf = overflow_seen;
         hyper_expected.push_back(res);
         run_multiple = '0;
         overflow_seen = 1'b0;
      end
   endfunction

   function automatic void add_period(input logic [PERIOD_W-1:0] p, input logic last);
      period_item_type it;
      it.period = p;
      it.last = last;
      pending_periods.push_back(it);
      items_queued++;
   endfunction

   // mostly short periods keep the divide loop short; a few use the full width
   function automatic logic [PERIOD_W-1:0] pick_period(input int span);
      if ($urandom_range(0, 49) == 0) return '0;
      case (span)
         0: return PERIOD_W'($urandom_range(1, 64));
         1: return PERIOD_W'($urandom_range(1, 1023));
         default: return PERIOD_W'($urandom);
      endcase
   endfunction

   function automatic void report_mismatch(input string what);
      if (mismatches < 10) $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatches++;
   endfunction

   // sender
   always @(posedge clock) begin : drive
      period_item_type it;
      logic            sent;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         sent = req_tvalid && req_tready;
         if (sent) fold_period(req_tdata, req_tlast);
         if (!req_tvalid || sent) begin
            if (pending_periods.size() != 0 && (calm || $urandom_range(0, 99) >= 17)) begin
               it = pending_periods.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= it.period;
               req_tlast  <= it.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver hold-off, once the block has delivered a few dozen results
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen == 30) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // receiver and checker
   always @(posedge clock) begin : watch
      hyper_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen <= results_seen + 1;
            if (hyper_expected.size() == 0) begin
               report_mismatch($sformatf("unexpected item tdata=%h tuser=%b",
                                         rsp_tdata, rsp_tuser));
            end else begin
               want = hyper_expected.pop_front();
               if (rsp_tdata !== {1'b0, want.hyper} || rsp_tuser !== want.ovf)
                  report_mismatch($sformatf("expected hyperperiod=%0d overflow=%b, got tdata=%h tuser=%b",
                                            want.hyper, want.ovf, rsp_tdata, rsp_tuser));
            end
         end
         rsp_tready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 17);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin : stimulus
      int len;
      int span;
      // directed sets
      add_period(16'd1, 1'b1);
      add_period(16'hFFFF, 1'b1);
      add_period(16'd0, 1'b1);
      add_period(16'd0, 1'b0);
      add_period(16'd0, 1'b0);
      add_period(16'd7, 1'b1);
      add_period(16'd12, 1'b0);
      add_period(16'd18, 1'b1);
      // overflow, then periods folded into a saturated set
      add_period(16'd65535, 1'b0);
      add_period(16'd65521, 1'b0);
      add_period(16'd65519, 1'b0);
      add_period(16'd65497, 1'b1);
      // just fits in 31 bits
      add_period(16'h8000, 1'b0);
      add_period(16'h4000, 1'b0);
      add_period(16'hFFFF, 1'b1);
      add_period(16'd2, 1'b0);
      add_period(16'h5555, 1'b0);
      add_period(16'hAAAA, 1'b1);
      // random sets
      while (items_queued < RANDOM_ITEMS + 18) begin
         len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
         span = $urandom_range(0, 99);
         span = (span < 60) ? 0 : (span < 85) ? 1 : 2;
         for (int i = 1; i <= len; i++) add_period(pick_period(span), i == len);
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_periods.size() != 0 || req_tvalid) @(posedge clock);
      while (hyper_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: hyperperiod_lcm.f
rtl/core/hpl_pkg.sv
rtl/core/hpl_div.sv
rtl/core/hpl_dp.sv
rtl/core/hpl_seq.sv
rtl/core/hyperperiod_lcm.sv
tb/hyperperiod_lcm_test.sv
